FILE: rtl/fdma_pkg.sv
// Shared types and constants for the frame delta moving average block.
// Used by fdma_ctrl, fdma_datapath and frame_delta_moving_average_core.
package fdma_pkg;

  localparam int COUNT_W       = 64;
  localparam int DELTA_W       = 48;
  localparam int INTERVAL_W    = 48;
  localparam int SINCE_W       = 49;
  localparam int MEAN_W        = 56;
  localparam int FRAC_W        = 8;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 64;

  localparam int DEFAULT_HISTORY_DEPTH = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_COUNT     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_INTERVAL = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_RING,
    ST_DIV_START,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic form_delta;
    logic ring_update;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

FILE: rtl/fdma_ctrl.sv
// Sequencer for the frame delta moving average block.
// Depends on fdma_pkg; drives the command struct into fdma_datapath.
module fdma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output fdma_pkg::cmd_t  cmd,
  input  fdma_pkg::status_t status
);
  import fdma_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_sample = 1'b1;
          state_next      = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.form_delta = 1'b1;
        state_next     = ST_RING;
      end
      ST_RING: begin
        cmd.ring_update = 1'b1;
        state_next      = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free or being emptied
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/fdma_datapath.sv
// Datapath: delta, elapsed total, delta ring with running sum, restoring
// divider for the mean and the refresh timer. Depends on fdma_pkg.
module fdma_datapath #(
  parameter int HISTORY_DEPTH = fdma_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fdma_pkg::cmd_t                       cmd,
  output fdma_pkg::status_t                    status,
  input  logic                                 cfg_write_en,
  input  logic [fdma_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fdma_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [fdma_pkg::COUNT_W-1:0]         counter_value,
  output logic [fdma_pkg::DELTA_W-1:0]         delta_ticks,
  output logic                                 delta_saturated,
  output logic [fdma_pkg::COUNT_W-1:0]         elapsed_ticks,
  output logic [fdma_pkg::MEAN_W-1:0]          mean_delta,
  output logic [fdma_pkg::MEAN_W-1:0]          shown_delta,
  output logic                                 shown_updated
);
  import fdma_pkg::*;

  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = DELTA_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  // configuration
  logic [COUNT_W-1:0]    start_count;
  logic [INTERVAL_W-1:0] update_interval;

  // sample and delta
  logic [COUNT_W-1:0] sample;
  logic [COUNT_W-1:0] previous_count;
  logic               reference_taken;
  logic [COUNT_W-1:0] elapsed_total;
  logic [DELTA_W-1:0] delta;
  logic               sat;
  logic [COUNT_W-1:0] raw;
  logic               raw_sat;

  // ring
  logic [DELTA_W-1:0] ring [HISTORY_DEPTH];
  logic [DELTA_W-1:0] ring_rd;
  logic [PTR_W-1:0]   wp;
  logic [FILL_W-1:0]  fill;
  logic [SUM_W-1:0]   ring_sum;
  logic [SUM_W-1:0]   ring_drop;
  logic               full;

  // refresh timer
  logic [SINCE_W-1:0] since_refresh;
  logic [MEAN_W-1:0]  shown_mean;
  logic               refreshed;

  // divider
  logic [DIV_W-1:0]   quot;
  logic [FILL_W-1:0]  rem;
  logic [CNT_W-1:0]   div_count;
  logic [FILL_W:0]    trial;
  logic               trial_ge;

  assign raw     = sample - (reference_taken ? previous_count : start_count);
  assign raw_sat = |raw[COUNT_W-1:DELTA_W];
  assign full    = (fill == FILL_W'(HISTORY_DEPTH));
  assign ring_drop = full ? SUM_W'(ring_rd) : '0;

  assign trial    = {rem, quot[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, fill});

  assign refreshed = (since_refresh >= SINCE_W'(update_interval));

  assign status.div_last = (div_count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_count     <= '0;
      update_interval <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_START_COUNT) begin
        start_count <= cfg_data;
      end else if (cfg_index == CFG_UPDATE_INTERVAL) begin
        update_interval <= cfg_data[INTERVAL_W-1:0];
      end
    end
  end

  // ring memory, registered read at the write pointer
  always_ff @(posedge clk) begin
    ring_rd <= ring[wp];
    if (cmd.ring_update) begin
      ring[wp] <= delta;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      sample <= counter_value;
    end
    if (cmd.form_delta) begin
      delta <= raw_sat ? {DELTA_W{1'b1}} : raw[DELTA_W-1:0];
      sat   <= raw_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_count  <= '0;
      reference_taken <= 1'b0;
      elapsed_total   <= '0;
      wp              <= '0;
      fill            <= '0;
      ring_sum        <= '0;
      since_refresh   <= '0;
      shown_mean      <= '0;
    end else begin
      if (cmd.form_delta) begin
        previous_count  <= sample;
        reference_taken <= 1'b1;
        elapsed_total   <= elapsed_total + raw;
      end
      if (cmd.ring_update) begin
        // oldest entry leaves the sum only once the ring is full
        ring_sum      <= ring_sum - ring_drop + SUM_W'(delta);
        since_refresh <= since_refresh + SINCE_W'(delta);
        if (!full) begin
          fill <= fill + FILL_W'(1);
        end
        if (wp == PTR_W'(HISTORY_DEPTH - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + PTR_W'(1);
        end
      end
      if (cmd.out_load && refreshed) begin
        since_refresh <= '0;
        shown_mean    <= quot[MEAN_W-1:0];
      end
    end
  end

  // restoring divider: (ring_sum << 8) / fill, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (cmd.div_start) begin
      div_count <= CNT_W'(DIV_W);
    end else if (cmd.div_step) begin
      div_count <= div_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot <= {ring_sum, {FRAC_W{1'b0}}};
      rem  <= '0;
    end else if (cmd.div_step) begin
      if (trial_ge) begin
        rem  <= FILL_W'(trial - {1'b0, fill});
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= trial[FILL_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      delta_ticks     <= delta;
      delta_saturated <= sat;
      elapsed_ticks   <= elapsed_total;
      mean_delta      <= quot[MEAN_W-1:0];
      shown_delta     <= refreshed ? quot[MEAN_W-1:0] : shown_mean;
      shown_updated   <= refreshed;
    end
  end

endmodule

FILE: rtl/frame_delta_moving_average_core.sv
// Frame delta moving average: per-sample tick delta, elapsed total, running
// mean over the last HISTORY_DEPTH deltas and interval-latched shown mean.
// Depends on fdma_pkg, fdma_ctrl and fdma_datapath.
//
// One counter sample in gives one result out. After the transfer in, each
// sample passes through the delta, ring update, divider load, divide and
// result load steps, where the restoring divider that forms the mean makes
// one quotient bit per cycle over DIV_W = 56 + clog2(HISTORY_DEPTH) bits.
// A waiting result holds the result load, and the next sample can be taken
// once the result is loaded.
// The block takes one sample at a time; a new sample is taken while the
// previous result is still waiting in the output register. Delta is saturated
// to 48 bits; the first sample after reset is referenced to start_count.
// Configuration writes are single-cycle and should only be made while the
// block is idle.
module frame_delta_moving_average_core #(
  parameter int HISTORY_DEPTH = fdma_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [fdma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fdma_pkg::COUNT_W-1:0]     counter_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fdma_pkg::DELTA_W-1:0]     delta_ticks,
  output logic                             delta_saturated,
  output logic [fdma_pkg::COUNT_W-1:0]     elapsed_ticks,
  output logic [fdma_pkg::MEAN_W-1:0]      mean_delta,
  output logic [fdma_pkg::MEAN_W-1:0]      shown_delta,
  output logic                             shown_updated
);
  import fdma_pkg::*;

  cmd_t    cmd;
  status_t status;

  fdma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  fdma_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .counter_value   (counter_value),
    .delta_ticks     (delta_ticks),
    .delta_saturated (delta_saturated),
    .elapsed_ticks   (elapsed_ticks),
    .mean_delta      (mean_delta),
    .shown_delta     (shown_delta),
    .shown_updated   (shown_updated)
  );

endmodule

FILE: tb/sv/frame_delta_moving_average_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for frame_delta_moving_average_core: a directed table of counter
// samples, then randomised phases under several interval settings, checked by a predictor.
// Depends on fdma_pkg and the core RTL.
module frame_delta_moving_average_core_test;
  import fdma_pkg::*;

  localparam int          HISTORY      = DEFAULT_HISTORY_DEPTH;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned RESULT_SLOTS = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;
  localparam logic [DELTA_W-1:0]     DELTA_MAX      = '1;
  localparam logic [COUNT_W-1:0]     START_REF      = 64'hFFFF_FFFF_FFFF_FF00;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic               sat;
    logic [COUNT_W-1:0] elapsed;
    logic [MEAN_W-1:0]  mean;
    logic [MEAN_W-1:0]  shown;
    logic               updated;
  } frame_result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               typed;
    frame_result_t      want;
  } sample_row_t;

  // Start reference is START_REF, interval 0, so every sample refreshes the shown mean.
  localparam int NUM_ROWS = 22;
  localparam sample_row_t SAMPLE_TABLE [NUM_ROWS] = '{
    '{64'hFFFF_FFFF_FFFF_FF64, 1'b1,
      '{48'd100, 1'b0, 64'd100, 56'h6400, 56'h6400, 1'b1}},
    // counter wraps forward through zero
    '{64'h0000_0000_0000_0000, 1'b1,
      '{48'd156, 1'b0, 64'h100, 56'h8000, 56'h8000, 1'b1}},
    '{64'h0000_0000_0000_0000, 1'b1,
      '{48'd0, 1'b0, 64'h100, 56'h5555, 56'h5555, 1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{48'hFFFF_FFFF_FFFF, 1'b1, 64'hFF, 56'h40_0000_0000_3FC0, 56'h40_0000_0000_3FC0,
        1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},   // one tick backwards
    '{64'h0000_FFFF_FFFF_FFFD, 1'b0, '0},   // largest delta that fits
    '{64'h0001_FFFF_FFFF_FFFD, 1'b0, '0},   // just over the 48-bit range
    '{64'h0001_FFFF_FFFF_FFFE, 1'b0, '0},
    '{64'h8000_0000_0000_0000, 1'b0, '0},
    '{64'h8000_0000_0000_0000, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAB_0000, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAC_1234, 1'b0, '0},
    '{64'hAAAA_AAAB_0000_0000, 1'b0, '0},
    '{64'hAAAA_AAAB_0000_0001, 1'b0, '0},
    // ring is full from here, oldest delta drops out of the sum
    '{64'hAAAA_AAAB_0000_0001, 1'b0, '0},
    '{64'hAAAA_BBBB_0000_0001, 1'b0, '0},
    '{64'hAAAB_0000_0000_0000, 1'b0, '0},
    '{64'hAAAB_0000_0000_0FFF, 1'b0, '0},
    '{64'hAAAB_0000_0001_0000, 1'b0, '0},
    '{64'hAAAB_7FFF_FFFF_FFFF, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   cfg_write_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [COUNT_W-1:0]     counter_value = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [DELTA_W-1:0]     delta_ticks;
  logic                   delta_saturated;
  logic [COUNT_W-1:0]     elapsed_ticks;
  logic [MEAN_W-1:0]      mean_delta;
  logic [MEAN_W-1:0]      shown_delta;
  logic                   shown_updated;

  frame_delta_moving_average_core u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .counter_value   (counter_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .delta_ticks     (delta_ticks),
    .delta_saturated (delta_saturated),
    .elapsed_ticks   (elapsed_ticks),
    .mean_delta      (mean_delta),
    .shown_delta     (shown_delta),
    .shown_updated   (shown_updated)
  );

  // Predictor state and its copy of the registers
  logic [COUNT_W-1:0]    start_reg         = '0;
  logic [INTERVAL_W-1:0] interval_reg      = '0;
  logic [COUNT_W-1:0]    last_count_seen   = '0;
  logic                  have_reference    = 1'b0;
  logic [COUNT_W-1:0]    elapsed_acc       = '0;
  logic [DELTA_W-1:0]    delta_window [HISTORY];
  int unsigned           window_pos        = 0;
  int unsigned           window_fill       = 0;
  logic [63:0]           window_sum        = '0;
  logic [63:0]           ticks_since_shown = '0;
  logic [MEAN_W-1:0]     shown_mean_copy   = '0;

  // expected results in transfer order, head and tail counters never wrap in a run
  frame_result_t pending_results [RESULT_SLOTS];
  int unsigned   pending_head   = 0;
  int unsigned   pending_tail   = 0;
  int unsigned   failures       = 0;
  int unsigned   results_seen   = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   sender_gap_max = 0;
  int unsigned   sink_stall_max = 0;
  bit            hold_pending   = 1'b0;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic frame_result_t predict_frame(input logic [COUNT_W-1:0] count);
    logic [COUNT_W-1:0] raw;
    logic [63:0]        scaled;
    frame_result_t      r;
    raw = count - (have_reference ? last_count_seen : start_reg);
    r.sat = (raw > COUNT_W'(DELTA_MAX));
    r.delta = r.sat ? DELTA_MAX : raw[DELTA_W-1:0];
    last_count_seen = count;
    have_reference = 1'b1;
    elapsed_acc += raw;
    if (window_fill == HISTORY) window_sum -= 64'(delta_window[window_pos]);
    else window_fill++;
    delta_window[window_pos] = r.delta;
    window_sum += 64'(r.delta);
    window_pos = (window_pos + 1) % HISTORY;
    scaled = (window_sum << FRAC_W) / 64'(window_fill);
    r.mean = scaled[MEAN_W-1:0];
    ticks_since_shown += 64'(r.delta);
    r.updated = (ticks_since_shown >= 64'(interval_reg));
    if (r.updated) begin
      ticks_since_shown = '0;
      shown_mean_copy = r.mean;
    end
    r.elapsed = elapsed_acc;
    r.shown = shown_mean_copy;
    return r;
  endfunction

  // Mostly small forward steps, some wide ones, some backwards, a few arbitrary values.
  function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] last);
    int unsigned        pick;
    int unsigned        width;
    logic [COUNT_W-1:0] step;
    pick = $urandom_range(0, 99);
    width = (pick < 60) ? $urandom_range(0, 20) : $urandom_range(0, DELTA_W + 1);
    step = {$urandom, $urandom};
    step &= (64'd1 << width) - 64'd1;
    if (pick < 85) return last + step;
    if (pick < 93) return last - step;
    return {$urandom, $urandom};
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("mismatch on %s, result %0d: expected %h, got %h", field, results_seen, want,
               got);
  endtask

  // Receiver: checks each transfer, then holds stall for a drawn number of valid cycles.
  always @(posedge clk) begin : receiver
    frame_result_t want;
    int unsigned   hold_for;
    if (rst) begin
      out_stall <= 1'b0;
      hold_for = 0;
    end else if (out_valid && !out_stall) begin
      if (pending_tail == pending_head) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result with no sample outstanding: delta_ticks %h", delta_ticks);
      end else begin
        want = pending_results[pending_head % RESULT_SLOTS];
        pending_head++;
        if (delta_ticks !== want.delta)
          note_mismatch("delta_ticks", 64'(want.delta), 64'(delta_ticks));
        if (delta_saturated !== want.sat)
          note_mismatch("delta_saturated", 64'(want.sat), 64'(delta_saturated));
        if (elapsed_ticks !== want.elapsed)
          note_mismatch("elapsed_ticks", want.elapsed, elapsed_ticks);
        if (mean_delta !== want.mean)
          note_mismatch("mean_delta", 64'(want.mean), 64'(mean_delta));
        if (shown_delta !== want.shown)
          note_mismatch("shown_delta", 64'(want.shown), 64'(shown_delta));
        if (shown_updated !== want.updated)
          note_mismatch("shown_updated", 64'(want.updated), 64'(shown_updated));
      end
      results_seen++;
      hold_for = $urandom_range(0, sink_stall_max);
      if (hold_pending) begin
        hold_for = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      out_stall <= (hold_for != 0);
    end else if (out_valid && out_stall) begin
      if (hold_for <= 1) begin
        hold_for = 0;
        out_stall <= 1'b0;
      end else begin
        hold_for--;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    if (index == CFG_START_COUNT) start_reg = value;
    else if (index == CFG_UPDATE_INTERVAL) interval_reg = value[INTERVAL_W-1:0];
  endtask

  // Offers one sample; returns at the edge of its transfer with valid still high.
  task automatic send_count(input logic [COUNT_W-1:0] count, input logic typed,
                            input frame_result_t want);
    int unsigned   gap;
    frame_result_t predicted;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    counter_value <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_frame(count);
    pending_results[pending_tail % RESULT_SLOTS] = typed ? want : predicted;
    pending_tail++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_tail != pending_head) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] interval, input int unsigned gap_max,
                           input int unsigned stall_max, input bit hold);
    write_reg(CFG_UPDATE_INTERVAL, interval);
    sender_gap_max = gap_max;
    sink_stall_max = stall_max;
    hold_pending = hold;
    repeat (PHASE_ITEMS) send_count(next_count(last_count_seen), 1'b0, '0);
    settle();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_START_COUNT, START_REF);
    write_reg(CFG_UPDATE_INTERVAL, '0);
    sender_gap_max = 17;
    sink_stall_max = 17;
    for (int i = 0; i < NUM_ROWS; i++)
      send_count(SAMPLE_TABLE[i].count, SAMPLE_TABLE[i].typed, SAMPLE_TABLE[i].want);
    settle();

    // start_count written after the first sample must not matter any more
    write_reg(CFG_START_COUNT, '1);
    run_phase('1, 17, 17, 1'b0);

    write_reg(CFG_UNUSED_LOW, 64'h0000_0000_0000_1234);
    write_reg(CFG_UNUSED_TOP, '1);
    write_reg(CFG_START_COUNT, '0);
    run_phase(64'hABCD_0000_0001_0000, 0, 0, 1'b0);

    // long receiver hold while the sender keeps offering back to back
    run_phase(CFG_DATA_W'($urandom_range(1, 1 << 22)), 0, 17, 1'b1);
    run_phase(64'd1, 17, 0, 1'b0);
    run_phase({$urandom, $urandom}, 17, 17, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_tail == pending_head) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fdma_pkg.sv
rtl/fdma_ctrl.sv
rtl/fdma_datapath.sv
rtl/frame_delta_moving_average_core.sv
tb/sv/frame_delta_moving_average_core_test.sv
